// File: rtl/id3_pkg.sv
// ----------------------------------------------------------------------------
// id3_pkg
// Types, constants and the UTF-8 encoder shared by the ID3 text transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package id3_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
      logic       no_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
      logic [7:0] text_length;
   } rsp_type;

   localparam int unsigned JOB_BYTES = 6;

   // work handed from the front end to the back end for one transaction
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                nb;
      logic                      eot;
      logic [7:0]                base;
   } job_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] b;
   } utf8_seq_type;

   typedef enum logic [1:0] {
      PHASE_AWAIT,
      PHASE_ACTIVE,
      PHASE_ENDED
   } phase_type;

   typedef enum logic [1:0] {
      MODE_LATIN1,
      MODE_UTF16,
      MODE_UTF8
   } mode_type;

   localparam logic [7:0]  SEL_LATIN1     = 8'h00;
   localparam logic [7:0]  SEL_UTF16_BOM  = 8'h01;
   localparam logic [7:0]  SEL_UTF16_BE   = 8'h02;
   localparam logic [7:0]  BOM_FF         = 8'hFF;
   localparam logic [7:0]  BOM_FE         = 8'hFE;
   localparam logic [15:0] HIGH_FIRST     = 16'hD800;
   localparam logic [15:0] HIGH_LAST      = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST      = 16'hDC00;
   localparam logic [15:0] LOW_LAST       = 16'hDFFF;
   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [20:0] SUPPLEMENT_BASE = 21'h010000;
   localparam logic [7:0]  LIMIT_RESET    = 8'hFF;

   function automatic utf8_seq_type utf8_encode(logic [20:0] cp);
      utf8_seq_type s;
      s = '0;
      if (cp < 21'h80) begin
         s.len  = 3'd1;
         s.b[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         s.len  = 3'd2;
         s.b[0] = {3'b110, cp[10:6]};
         s.b[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         s.len  = 3'd3;
         s.b[0] = {4'b1110, cp[15:12]};
         s.b[1] = {2'b10, cp[11:6]};
         s.b[2] = {2'b10, cp[5:0]};
      end else begin
         s.len  = 3'd4;
         s.b[0] = {5'b11110, cp[20:18]};
         s.b[1] = {2'b10, cp[17:12]};
         s.b[2] = {2'b10, cp[11:6]};
         s.b[3] = {2'b10, cp[5:0]};
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/id3_front.sv
// ----------------------------------------------------------------------------
// id3_front
// Accepts frame bytes, tracks encoding and frame state, and turns each
// transaction into a job of up to six UTF-8 bytes plus an optional end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module id3_front #(
   parameter int BUF_BYTES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire id3_pkg::req_type  req,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output id3_pkg::job_type       job
);

   localparam logic [7:0] LimCap = 8'(BUF_BYTES - 1);

   typedef struct packed {
      logic                               ok;
      logic [7:0]                         cnt;
      logic [2:0]                         nb;
      logic [id3_pkg::JOB_BYTES-1:0][7:0] bytes;
   } acc_type;

   function automatic acc_type emit_seq(acc_type a, id3_pkg::utf8_seq_type s,
                                        logic [7:0] lim);
      acc_type    r;
      logic [8:0] sum;
      logic [2:0] idx;
      r   = a;
      sum = {1'b0, a.cnt} + {6'b0, s.len};
      idx = '0;
      if (sum > {1'b0, lim}) begin
         r.ok = 1'b0;
      end else begin
         r.ok  = 1'b1;
         r.cnt = sum[7:0];
         r.nb  = a.nb + s.len;
         for (int k = 0; k < 4; k++) begin
            idx = a.nb + 3'(k);
            if ((3'(k) < s.len) && (idx < 3'(id3_pkg::JOB_BYTES))) begin
               r.bytes[idx] = s.b[k];
            end
         end
      end
      return r;
   endfunction

   logic [7:0]          lim_ff, lim_in;
   id3_pkg::phase_type  phase_ff, phase_in;
   id3_pkg::mode_type   mode_ff, mode_in;
   logic                le_ff, le_in;
   logic                first_ff, first_in;
   logic                pend_v_ff, pend_v_in;
   logic [7:0]          pend_ff, pend_in;
   logic                hs_v_ff, hs_v_in;
   logic [9:0]          hs_ff, hs_in;
   logic [23:0]         sbuf_ff, sbuf_in;
   logic [2:0]          need_ff, need_in;
   logic [1:0]          have_ff, have_in;
   logic [7:0]          count_ff, count_in;
   logic                stop_ff, stop_in;
   logic [7:0]          lim;
   logic                accept;
   acc_type             acc;
   logic                eot;

   assign lim       = (lim_ff > LimCap) ? LimCap : lim_ff;
   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign job_valid = req_valid && ((acc.nb != 3'd0) || eot);

   always_comb begin
      job.bytes = acc.bytes;
      job.nb    = acc.nb;
      job.eot   = eot;
      job.base  = count_ff;
   end

   always_comb begin
      logic [7:0]            b;
      logic [15:0]           unit;
      logic                  is_high;
      logic                  is_low;
      logic                  unit_ok;
      logic                  do_unit;
      logic [2:0]            lead_len;
      id3_pkg::utf8_seq_type s8;

      lim_in    = csr_wr_en ? csr_wr_data : lim_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      le_in     = le_ff;
      first_in  = first_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      hs_v_in   = hs_v_ff;
      hs_in     = hs_ff;
      sbuf_in   = sbuf_ff;
      need_in   = need_ff;
      have_in   = have_ff;
      stop_in   = stop_ff;
      acc       = '0;
      acc.ok    = 1'b1;
      acc.cnt   = count_ff;
      eot       = 1'b0;
      b         = req.in_byte;
      unit      = '0;
      is_high   = 1'b0;
      is_low    = 1'b0;
      unit_ok   = 1'b0;
      do_unit   = 1'b0;
      lead_len  = 3'd1;
      s8        = '0;

      if (!req.no_byte) begin
         unique case (phase_ff)
            id3_pkg::PHASE_AWAIT: begin
               if (b == id3_pkg::SEL_LATIN1) begin
                  mode_in = id3_pkg::MODE_LATIN1;
               end else if (b == id3_pkg::SEL_UTF16_BOM || b == id3_pkg::SEL_UTF16_BE) begin
                  mode_in = id3_pkg::MODE_UTF16;
               end else begin
                  mode_in = id3_pkg::MODE_UTF8;
               end
               phase_in = id3_pkg::PHASE_ACTIVE;
            end
            id3_pkg::PHASE_ACTIVE: begin
               if (!stop_ff) begin
                  unique case (mode_ff)
                     id3_pkg::MODE_LATIN1: begin
                        if (b == 8'd0) begin
                           phase_in = id3_pkg::PHASE_ENDED;
                        end else begin
                           acc = emit_seq(acc, id3_pkg::utf8_encode({13'd0, b}), lim);
                           if (!acc.ok) stop_in = 1'b1;
                        end
                     end
                     id3_pkg::MODE_UTF16: begin
                        if (!pend_v_ff) begin
                           pend_v_in = 1'b1;
                           pend_in   = b;
                        end else begin
                           pend_v_in = 1'b0;
                           unit_ok   = 1'b1;
                           if (first_ff) begin
                              first_in = 1'b0;
                              if (pend_ff == id3_pkg::BOM_FF && b == id3_pkg::BOM_FE) begin
                                 le_in   = 1'b1;
                                 unit_ok = 1'b0;
                              end else if (pend_ff == id3_pkg::BOM_FE &&
                                           b == id3_pkg::BOM_FF) begin
                                 unit_ok = 1'b0;
                              end
                           end
                           unit    = le_ff ? {b, pend_ff} : {pend_ff, b};
                           is_high = (unit >= id3_pkg::HIGH_FIRST) &&
                                     (unit <= id3_pkg::HIGH_LAST);
                           is_low  = (unit >= id3_pkg::LOW_FIRST) &&
                                     (unit <= id3_pkg::LOW_LAST);
                           if (unit_ok) begin
                              if (hs_v_ff) begin
                                 hs_v_in = 1'b0;
                                 if (is_low) begin
                                    acc = emit_seq(acc, id3_pkg::utf8_encode(
                                          id3_pkg::SUPPLEMENT_BASE +
                                          {1'b0, hs_ff, unit[9:0]}), lim);
                                    if (!acc.ok) stop_in = 1'b1;
                                 end else begin
                                    acc = emit_seq(acc,
                                          id3_pkg::utf8_encode(id3_pkg::REPLACEMENT_CP), lim);
                                    if (!acc.ok) stop_in = 1'b1;
                                    else do_unit = 1'b1;
                                 end
                              end else begin
                                 do_unit = 1'b1;
                              end
                              if (do_unit) begin
                                 priority if (unit == 16'd0) begin
                                    phase_in = id3_pkg::PHASE_ENDED;
                                 end else if (is_high) begin
                                    hs_v_in = 1'b1;
                                    hs_in   = unit[9:0];
                                 end else if (is_low) begin
                                    acc = emit_seq(acc,
                                          id3_pkg::utf8_encode(id3_pkg::REPLACEMENT_CP), lim);
                                    if (!acc.ok) stop_in = 1'b1;
                                 end else begin
                                    acc = emit_seq(acc,
                                          id3_pkg::utf8_encode({5'd0, unit}), lim);
                                    if (!acc.ok) stop_in = 1'b1;
                                 end
                              end
                           end
                        end
                     end
                     id3_pkg::MODE_UTF8: begin
                        if (need_ff == 3'd0) begin
                           if (b == 8'd0) begin
                              phase_in = id3_pkg::PHASE_ENDED;
                           end else begin
                              priority if (!b[7]) lead_len = 3'd1;
                              else if (b[7:5] == 3'b110) lead_len = 3'd2;
                              else if (b[7:4] == 4'b1110) lead_len = 3'd3;
                              else if (b[7:3] == 5'b11110) lead_len = 3'd4;
                              else lead_len = 3'd1;
                              if (lead_len == 3'd1) begin
                                 s8.len  = 3'd1;
                                 s8.b[0] = b;
                                 acc = emit_seq(acc, s8, lim);
                                 if (!acc.ok) stop_in = 1'b1;
                              end else begin
                                 sbuf_in = {16'd0, b};
                                 need_in = lead_len;
                                 have_in = 2'd1;
                              end
                           end
                        end else if (({1'b0, have_ff} + 3'd1) < need_ff) begin
                           sbuf_in = {sbuf_ff[15:0], b};
                           have_in = have_ff + 2'd1;
                        end else begin
                           s8.len = {1'b0, have_ff} + 3'd1;
                           unique case (have_ff)
                              2'd1: begin
                                 s8.b[0] = sbuf_ff[7:0];
                                 s8.b[1] = b;
                              end
                              2'd2: begin
                                 s8.b[0] = sbuf_ff[15:8];
                                 s8.b[1] = sbuf_ff[7:0];
                                 s8.b[2] = b;
                              end
                              2'd3: begin
                                 s8.b[0] = sbuf_ff[23:16];
                                 s8.b[1] = sbuf_ff[15:8];
                                 s8.b[2] = sbuf_ff[7:0];
                                 s8.b[3] = b;
                              end
                              default: begin
                                 s8.b[0] = b;
                              end
                           endcase
                           sbuf_in = '0;
                           need_in = 3'd0;
                           have_in = 2'd0;
                           acc = emit_seq(acc, s8, lim);
                           if (!acc.ok) stop_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      count_in = acc.cnt;

      if (req.last_byte) begin
         // a held high surrogate at frame end becomes a replacement char
         if (phase_in == id3_pkg::PHASE_ACTIVE && !stop_in &&
             mode_in == id3_pkg::MODE_UTF16 && hs_v_in) begin
            acc = emit_seq(acc, id3_pkg::utf8_encode(id3_pkg::REPLACEMENT_CP), lim);
         end
         eot       = 1'b1;
         phase_in  = id3_pkg::PHASE_AWAIT;
         mode_in   = id3_pkg::MODE_LATIN1;
         le_in     = 1'b0;
         first_in  = 1'b1;
         pend_v_in = 1'b0;
         pend_in   = '0;
         hs_v_in   = 1'b0;
         hs_in     = '0;
         sbuf_in   = '0;
         need_in   = 3'd0;
         have_in   = 2'd0;
         count_in  = 8'd0;
         stop_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff    <= id3_pkg::LIMIT_RESET;
         phase_ff  <= id3_pkg::PHASE_AWAIT;
         mode_ff   <= id3_pkg::MODE_LATIN1;
         le_ff     <= 1'b0;
         first_ff  <= 1'b1;
         pend_v_ff <= 1'b0;
         pend_ff   <= '0;
         hs_v_ff   <= 1'b0;
         hs_ff     <= '0;
         sbuf_ff   <= '0;
         need_ff   <= 3'd0;
         have_ff   <= 2'd0;
         count_ff  <= 8'd0;
         stop_ff   <= 1'b0;
      end else begin
         lim_ff <= lim_in;
         if (accept) begin
            phase_ff  <= phase_in;
            mode_ff   <= mode_in;
            le_ff     <= le_in;
            first_ff  <= first_in;
            pend_v_ff <= pend_v_in;
            pend_ff   <= pend_in;
            hs_v_ff   <= hs_v_in;
            hs_ff     <= hs_in;
            sbuf_ff   <= sbuf_in;
            need_ff   <= need_in;
            have_ff   <= have_in;
            count_ff  <= count_in;
            stop_ff   <= stop_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/id3_queue.sv
// ----------------------------------------------------------------------------
// id3_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module id3_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire id3_pkg::job_type  in_job,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output id3_pkg::job_type       out_job
);

   id3_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/id3_back.sv
// ----------------------------------------------------------------------------
// id3_back
// Takes jobs from the queue and sends their bytes and end marker one result
// per cycle through the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module id3_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire id3_pkg::job_type  job,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output id3_pkg::rsp_type       rsp
);

   id3_pkg::job_type job_ff, job_in;
   logic             job_v_ff, job_v_in;
   logic [2:0]       idx_ff, idx_in;
   logic             rsp_v_ff, rsp_v_in;
   id3_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0]       items;
   logic             out_free;
   logic             emit_now;
   logic             done;

   assign items     = job_ff.nb + {2'b0, job_ff.eot};
   assign out_free  = !rsp_v_ff || rsp_ready;
   assign emit_now  = job_v_ff && out_free;
   assign done      = emit_now && (idx_ff == items - 3'd1);
   assign job_ready = !job_v_ff || done;
   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      job_in   = job_ff;
      job_v_in = job_v_ff;
      idx_in   = idx_ff;
      rsp_v_in = rsp_v_ff;
      rsp_in   = rsp_ff;
      if (out_free) begin
         rsp_v_in = 1'b0;
      end
      if (emit_now) begin
         rsp_v_in = 1'b1;
         if (idx_ff < job_ff.nb) begin
            rsp_in.out_byte    = job_ff.bytes[idx_ff];
            rsp_in.byte_valid  = 1'b1;
            rsp_in.end_of_text = 1'b0;
            rsp_in.text_length = job_ff.base + {5'd0, idx_ff} + 8'd1;
         end else begin
            rsp_in.out_byte    = 8'd0;
            rsp_in.byte_valid  = 1'b0;
            rsp_in.end_of_text = 1'b1;
            rsp_in.text_length = job_ff.base + {5'd0, job_ff.nb};
         end
         idx_in = idx_ff + 3'd1;
      end
      if (done) begin
         job_v_in = 1'b0;
      end
      if (job_valid && job_ready) begin
         job_in   = job;
         job_v_in = 1'b1;
         idx_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_v_ff <= 1'b0;
         idx_ff   <= 3'd0;
         rsp_v_ff <= 1'b0;
      end else begin
         job_v_ff <= job_v_in;
         idx_ff   <= idx_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_ff.byte_valid != rsp_ff.end_of_text))
      else $error("result is neither exactly a byte nor an end marker");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.end_of_text |-> (rsp_ff.out_byte == 8'd0))
      else $error("end marker carries a nonzero byte");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      job_v_ff |-> (idx_ff < items))
      else $error("back end index past end of job");

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_v_ff |-> (items != 3'd0))
      else $error("empty job reached the back end");

   a_next_length: assert property (@(posedge clock) disable iff (reset)
      emit_now && (idx_ff != 3'd0) && (idx_ff < job_ff.nb) |=>
         (rsp_ff.text_length == $past(job_ff.base) + {5'd0, $past(idx_ff)} + 8'd1))
      else $error("text length does not follow byte position");

endmodule

`default_nettype wire

// File: rtl/id3_text_to_utf8.sv
// ----------------------------------------------------------------------------
// id3_text_to_utf8
// ID3v2 text frame body to UTF-8 transcoder with a capacity limit and an end
// marker per frame.
// ----------------------------------------------------------------------------
// path: a transaction's job is registered in the job queue, then in the back
//   end's job register, and its results are then held in the output register
// throughput: the front end takes one transaction per cycle while the
//   two-entry job queue has room; the back end sends one result per cycle
//   while the output is not stalled, one for each job byte plus the marker
// reset: synchronous, clears frame state, queue and output; limit becomes 255
`default_nettype none

module id3_text_to_utf8 #(
   parameter int BUF_BYTES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire id3_pkg::req_type  req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output id3_pkg::rsp_type       rsp
);

   logic             f_valid;
   logic             f_ready;
   id3_pkg::job_type f_job;
   logic             b_valid;
   logic             b_ready;
   id3_pkg::job_type b_job;

   id3_front #(
      .BUF_BYTES(BUF_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .job_valid  (f_valid),
      .job_ready  (f_ready),
      .job        (f_job)
   );

   id3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_job   (f_job),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_job  (b_job)
   );

   id3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(b_valid),
      .job_ready(b_ready),
      .job      (b_job),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// File: bench/id3_utf8_checker.sv
// ----------------------------------------------------------------------------
// id3_utf8_checker
// Watches the request, response and CSR ports of the ID3 text transcoder,
// keeps its own model of the frame decoder and compares each response
// transaction with the oldest predicted UTF-8 byte or end marker.
// ----------------------------------------------------------------------------
module id3_utf8_checker #(
   parameter int BUF_BYTES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire id3_pkg::req_type req,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire id3_pkg::rsp_type rsp,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 200;

   id3_pkg::phase_type frame_phase;
   id3_pkg::mode_type  enc_mode;
   logic               little_end;
   logic               first_unit;
   logic [8:0]         lo_pending;
   logic [16:0]        hi_held;
   logic [23:0]        lead_bytes;
   int                 seq_need;
   int                 seq_have;
   int                 emitted;
   logic               capped;
   logic [7:0]         max_bytes;
   id3_pkg::rsp_type   expected_utf8[$];
   id3_pkg::rsp_type   oldest;
   int                 errors;

   function automatic id3_pkg::rsp_type utf8_result(logic [7:0] b, logic v, logic e,
                                                    logic [7:0] n);
      id3_pkg::rsp_type r;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.end_of_text = e;
      r.text_length = n;
      return r;
   endfunction

   task automatic clear_frame_state();
      frame_phase = id3_pkg::PHASE_AWAIT;
      enc_mode    = id3_pkg::MODE_LATIN1;
      little_end  = 1'b0;
      first_unit  = 1'b1;
      lo_pending  = '0;
      hi_held     = '0;
      lead_bytes  = '0;
      seq_need    = 0;
      seq_have    = 0;
      emitted     = 0;
      capped      = 1'b0;
   endtask

   // whole sequence or nothing; a sequence that does not fit stops the frame
   task automatic push_text(input logic [3:0][7:0] s, input int len, output bit fits);
      int lim;
      lim  = (int'(max_bytes) > BUF_BYTES - 1) ? BUF_BYTES - 1 : int'(max_bytes);
      fits = (emitted + len <= lim);
      if (!fits) begin
         capped = 1'b1;
      end else begin
         for (int k = 0; k < len; k++) begin
            emitted++;
            expected_utf8.push_back(utf8_result(s[k], 1'b1, 1'b0, emitted[7:0]));
         end
      end
   endtask

   task automatic push_code(input logic [20:0] cp, output bit fits);
      logic [3:0][7:0] s;
      int              n;
      s = '0;
      if (cp < 21'h80) begin
         n    = 1;
         s[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         n    = 2;
         s[0] = 8'hC0 | {3'b000, cp[10:6]};
         s[1] = 8'h80 | {2'b00, cp[5:0]};
      end else if (cp < 21'h10000) begin
         n    = 3;
         s[0] = 8'hE0 | {4'b0000, cp[15:12]};
         s[1] = 8'h80 | {2'b00, cp[11:6]};
         s[2] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         n    = 4;
         s[0] = 8'hF0 | {5'b00000, cp[20:18]};
         s[1] = 8'h80 | {2'b00, cp[17:12]};
         s[2] = 8'h80 | {2'b00, cp[11:6]};
         s[3] = 8'h80 | {2'b00, cp[5:0]};
      end
      push_text(s, n, fits);
   endtask

   task automatic take_unit(input logic [15:0] u);
      logic [15:0] hi;
      int          cp;
      bit          fits;
      if (hi_held[16]) begin
         hi      = hi_held[15:0];
         hi_held = '0;
         if (u >= id3_pkg::LOW_FIRST && u <= id3_pkg::LOW_LAST) begin
            cp = 'h10000 + ((int'(hi) - int'(id3_pkg::HIGH_FIRST)) << 10) +
                 (int'(u) - int'(id3_pkg::LOW_FIRST));
            push_code(cp[20:0], fits);
            return;
         end
         push_code(id3_pkg::REPLACEMENT_CP, fits);
         if (!fits) return;
      end
      if (u == 16'h0000) begin
         frame_phase = id3_pkg::PHASE_ENDED;
      end else if (u >= id3_pkg::HIGH_FIRST && u <= id3_pkg::HIGH_LAST) begin
         hi_held = {1'b1, u};
      end else if (u >= id3_pkg::LOW_FIRST && u <= id3_pkg::LOW_LAST) begin
         push_code(id3_pkg::REPLACEMENT_CP, fits);
      end else begin
         push_code({5'd0, u}, fits);
      end
   endtask

   task automatic take_utf16_byte(input logic [7:0] b);
      logic [7:0] b0;
      if (!lo_pending[8]) begin
         lo_pending = {1'b1, b};
         return;
      end
      b0         = lo_pending[7:0];
      lo_pending = '0;
      // byte order mark only counts as the first unit
      if (first_unit) begin
         first_unit = 1'b0;
         if (b0 == id3_pkg::BOM_FF && b == id3_pkg::BOM_FE) begin
            little_end = 1'b1;
            return;
         end
         if (b0 == id3_pkg::BOM_FE && b == id3_pkg::BOM_FF) return;
      end
      take_unit(little_end ? {b, b0} : {b0, b});
   endtask

   task automatic take_utf8_byte(input logic [7:0] b);
      logic [3:0][7:0] s;
      bit              fits;
      s = '0;
      if (seq_need == 0) begin
         if (b == 8'h00) begin
            frame_phase = id3_pkg::PHASE_ENDED;
            return;
         end
         if (b[7:5] == 3'b110) seq_need = 2;
         else if (b[7:4] == 4'b1110) seq_need = 3;
         else if (b[7:3] == 5'b11110) seq_need = 4;
         else seq_need = 1;
         if (seq_need == 1) begin
            seq_need = 0;
            s[0]     = b;
            push_text(s, 1, fits);
            return;
         end
         lead_bytes = {16'd0, b};
         seq_have   = 1;
         return;
      end
      if (seq_have + 1 < seq_need) begin
         lead_bytes = {lead_bytes[15:0], b};
         seq_have++;
         return;
      end
      // continuation bytes pass unchecked
      for (int k = 0; k < seq_have; k++) s[k] = lead_bytes[8*(seq_have-1-k) +: 8];
      s[seq_have] = b;
      push_text(s, seq_have + 1, fits);
      seq_need   = 0;
      seq_have   = 0;
      lead_bytes = '0;
   endtask

   task automatic take_byte(input logic [7:0] b);
      bit fits;
      if (frame_phase == id3_pkg::PHASE_AWAIT) begin
         if (b == id3_pkg::SEL_LATIN1) enc_mode = id3_pkg::MODE_LATIN1;
         else if (b == id3_pkg::SEL_UTF16_BOM || b == id3_pkg::SEL_UTF16_BE)
            enc_mode = id3_pkg::MODE_UTF16;
         else enc_mode = id3_pkg::MODE_UTF8;
         frame_phase = id3_pkg::PHASE_ACTIVE;
         return;
      end
      if (frame_phase != id3_pkg::PHASE_ACTIVE || capped) return;
      case (enc_mode)
         id3_pkg::MODE_LATIN1: begin
            if (b == 8'h00) frame_phase = id3_pkg::PHASE_ENDED;
            else push_code({13'd0, b}, fits);
         end
         id3_pkg::MODE_UTF16: begin
            take_utf16_byte(b);
         end
         default: begin
            take_utf8_byte(b);
         end
      endcase
   endtask

   task automatic transcode_item(input id3_pkg::req_type it);
      bit fits;
      if (!it.no_byte) take_byte(it.in_byte);
      if (it.last_byte) begin
         // a high surrogate left at frame end becomes a replacement character
         if (frame_phase == id3_pkg::PHASE_ACTIVE && !capped &&
             enc_mode == id3_pkg::MODE_UTF16 && hi_held[16]) begin
            hi_held = '0;
            push_code(id3_pkg::REPLACEMENT_CP, fits);
         end
         expected_utf8.push_back(utf8_result(8'h00, 1'b0, 1'b1, emitted[7:0]));
         clear_frame_state();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         max_bytes = id3_pkg::LIMIT_RESET;
         clear_frame_state();
         expected_utf8.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) max_bytes = csr_wr_data;
         if (req_valid && req_ready) transcode_item(req);
         if (rsp_valid && rsp_ready) begin
            if (expected_utf8.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected transaction out_byte=%h valid=%b eot=%b len=%0d",
                           $time, rsp.out_byte, rsp.byte_valid, rsp.end_of_text,
                           rsp.text_length);
            end else begin
               oldest = expected_utf8.pop_front();
               if (rsp.out_byte !== oldest.out_byte || rsp.byte_valid !== oldest.byte_valid ||
                   rsp.end_of_text !== oldest.end_of_text ||
                   rsp.text_length !== oldest.text_length) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: expected %h/%b/%b/%0d actual %h/%b/%b/%0d",
                              $time, oldest.out_byte, oldest.byte_valid, oldest.end_of_text,
                              oldest.text_length, rsp.out_byte, rsp.byte_valid,
                              rsp.end_of_text, rsp.text_length);
               end
            end
         end
      end
      mismatches  <= errors;
      outstanding <= expected_utf8.size();
   end

endmodule

// File: bench/tb_id3_text_to_utf8.sv
// ----------------------------------------------------------------------------
// tb_id3_text_to_utf8
// Drives ID3 text frames in Latin-1, UTF-16 and UTF-8 into the transcoder
// under several capacity limits and flow-control patterns; the checker
// beside the block predicts and compares every response transaction.
// ----------------------------------------------------------------------------
module tb_id3_text_to_utf8;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [7:0]       csr_wr_data = 8'h00;
   logic             req_valid   = 1'b0;
   id3_pkg::req_type req         = '0;
   logic             req_ready;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   id3_pkg::rsp_type rsp;
   int               mismatches;
   int               outstanding;

   int               idle_pct  = 0;
   int               stall_pct = 0;
   bit               hold_go   = 1'b0;
   int               hold_left = 0;
   int               sent_items = 0;
   int               quiet;
   id3_pkg::req_type frame_q[$];

   id3_text_to_utf8 #(.BUF_BYTES(256)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   id3_utf8_checker #(.BUF_BYTES(256)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input id3_pkg::req_type it);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req       <= it;
      do @(posedge clock); while (!req_ready);
      if (!(it.no_byte && !it.last_byte)) sent_items++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_item(frame_q[i]);
      frame_q.delete();
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last, input logic nob);
      id3_pkg::req_type it;
      it.in_byte   = b;
      it.last_byte = last;
      it.no_byte   = nob;
      frame_q.push_back(it);
   endtask

   // body byte, sometimes preceded by a byte-less filler transaction
   task automatic queue_body(input logic [7:0] b);
      if ($urandom_range(9) == 0) queue_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      queue_byte(b, 1'b0, 1'b0);
   endtask

   task automatic queue_unit(input logic [15:0] u, input bit le);
      if (le) begin
         queue_body(u[7:0]);
         queue_body(u[15:8]);
      end else begin
         queue_body(u[15:8]);
         queue_body(u[7:0]);
      end
   endtask

   task automatic build_random_frame();
      int               kind;
      int               n;
      int               r;
      bit               le;
      logic [15:0]      u;
      id3_pkg::req_type tail;
      frame_q.delete();
      kind = $urandom_range(15);
      if (kind == 0) begin
         queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
         return;
      end
      if (kind <= 4) begin
         queue_byte(id3_pkg::SEL_LATIN1, 1'b0, 1'b0);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++)
            queue_body(($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else if (kind <= 10) begin
         queue_byte(8'($urandom_range(id3_pkg::SEL_UTF16_BOM, id3_pkg::SEL_UTF16_BE)),
                    1'b0, 1'b0);
         r  = $urandom_range(2);
         le = (r == 1);
         if (r == 1) begin
            queue_body(id3_pkg::BOM_FF);
            queue_body(id3_pkg::BOM_FE);
         end else if (r == 2) begin
            queue_body(id3_pkg::BOM_FE);
            queue_body(id3_pkg::BOM_FF);
         end
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(19);
            if (r < 7) begin
               u = $urandom_range(1) ? 16'($urandom_range(16'h0080, 16'hD7FF))
                                     : 16'($urandom_range(16'hE000, 16'hFFFF));
               queue_unit(u, le);
            end else if (r < 11) begin
               queue_unit(16'($urandom_range(id3_pkg::HIGH_FIRST, id3_pkg::HIGH_LAST)), le);
               queue_unit(16'($urandom_range(id3_pkg::LOW_FIRST, id3_pkg::LOW_LAST)), le);
            end else if (r < 13) begin
               queue_unit(16'($urandom_range(id3_pkg::HIGH_FIRST, id3_pkg::HIGH_LAST)), le);
            end else if (r < 15) begin
               queue_unit(16'($urandom_range(id3_pkg::LOW_FIRST, id3_pkg::LOW_LAST)), le);
            end else if (r < 19) begin
               queue_unit(16'($urandom_range(1, 16'h007F)), le);
            end else begin
               queue_unit(16'h0000, le);
            end
         end
         if ($urandom_range(5) == 0) queue_body(8'($urandom_range(255)));
      end else begin
         queue_byte(8'($urandom_range(8'h03, 8'hFF)), 1'b0, 1'b0);
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(9);
            case (r)
               0, 1, 2: queue_body(8'($urandom_range(1, 8'h7F)));
               3: begin
                  queue_body(8'($urandom_range(8'hC2, 8'hDF)));
                  queue_body(8'($urandom_range(8'h80, 8'hBF)));
               end
               4: begin
                  queue_body(8'($urandom_range(8'hE0, 8'hEF)));
                  repeat (2) queue_body(8'($urandom_range(8'h80, 8'hBF)));
               end
               5: begin
                  queue_body(8'($urandom_range(8'hF0, 8'hF7)));
                  repeat (3) queue_body(8'($urandom_range(8'h80, 8'hBF)));
               end
               6: queue_body($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                               : 8'($urandom_range(8'hF8, 8'hFF)));
               7: begin
                  queue_body(8'($urandom_range(8'hC0, 8'hDF)));
                  queue_body(8'($urandom_range(255)));
               end
               8: queue_body(8'h00);
               default: begin
                  queue_body(8'($urandom_range(8'hE0, 8'hEF)));
                  queue_body(8'($urandom_range(8'h80, 8'hBF)));
               end
            endcase
         end
      end
      if ($urandom_range(3) == 0) begin
         queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
      end else begin
         tail           = frame_q.pop_back();
         tail.last_byte = 1'b1;
         frame_q.push_back(tail);
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) begin
         build_random_frame();
         send_frame();
      end
   endtask

   // wait for every predicted transaction and let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [7:0] lim);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty frame, then a byte-less item that does nothing
      queue_byte(8'h5A, 1'b1, 1'b1);
      queue_byte(8'hC3, 1'b0, 1'b1);
      // latin-1 extremes, zero ends the text, trailing byte ignored
      queue_byte(id3_pkg::SEL_LATIN1, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h41, 1'b1, 1'b0);
      // utf-16 little endian: pair, lone low, high left at end with odd byte
      queue_byte(id3_pkg::SEL_UTF16_BOM, 1'b0, 1'b0);
      queue_byte(id3_pkg::BOM_FF, 1'b0, 1'b0);
      queue_byte(id3_pkg::BOM_FE, 1'b0, 1'b0);
      queue_byte(8'h3D, 1'b0, 1'b0);
      queue_byte(8'hD8, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hDE, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hDC, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hD8, 1'b0, 1'b0);
      queue_byte(8'h7A, 1'b1, 1'b0);
      // utf-16 with big endian mark, high surrogate followed by plain unit
      queue_byte(id3_pkg::SEL_UTF16_BE, 1'b0, 1'b0);
      queue_byte(id3_pkg::BOM_FE, 1'b0, 1'b0);
      queue_byte(id3_pkg::BOM_FF, 1'b0, 1'b0);
      queue_byte(8'hD8, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h41, 1'b1, 1'b0);
      // utf-8 copy: zero continuation, truncated sequence at end
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'hC3, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hE2, 1'b1, 1'b0);
      send_frame();
      run_random(12);

      set_limit(8'd0);
      idle_pct = 74;
      run_random(8);

      set_limit(8'd5);
      idle_pct  = 0;
      stall_pct = 74;
      hold_go   = 1'b1;
      run_random(12);

      set_limit(8'd255);
      idle_pct  = 32;
      stall_pct = 32;
      run_random(6);
      settle();
      run_random(6);

      set_limit(8'($urandom_range(1, 40)));
      idle_pct  = 0;
      stall_pct = 0;
      // long latin-1 frame runs into the capacity limit
      queue_byte(id3_pkg::SEL_LATIN1, 1'b0, 1'b0);
      for (int i = 0; i < 24; i++) queue_byte(8'h80 | 8'($urandom_range(127)), i == 23, 1'b0);
      send_frame();
      run_random(8);

      settle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
